[design/svs_pkg.sv]
package svs_pkg;

   // configuration port
   localparam int CSR_W = 60;
   localparam int IDX_W = 3;
   localparam logic [IDX_W-1:0] REG_LIGHT_IS_DIR   = 3'd0;
   localparam logic [IDX_W-1:0] REG_LIGHT_POS      = 3'd1;
   localparam logic [IDX_W-1:0] REG_LIGHT_DIR      = 3'd2;
   localparam logic [IDX_W-1:0] REG_LIGHT_RANGE    = 3'd3;
   localparam logic [IDX_W-1:0] REG_LIGHT_ENERGY   = 3'd4;
   localparam logic [IDX_W-1:0] REG_CAMERA_POS     = 3'd5;
   localparam logic [IDX_W-1:0] REG_OBJECT_CENTER  = 3'd6;

   localparam int NORMAL_W = 16;
   localparam int DIR_W    = 16;
   localparam int RANGE_W  = 19;
   localparam int ENERGY_W = 16;

   // saturated coordinate difference and squared distances
   localparam int SAT_W = 21;
   localparam logic [SAT_W-1:0] DIFF_LIMIT = 21'h100000;
   localparam int SQ_W   = 42;
   localparam int ROOT_W = 21;
   localparam int REM_W  = ROOT_W + 2;

   // strength divider
   localparam int DEN_W      = 22;
   localparam int NUM_W      = 26;
   localparam int QUOT_W     = 20;
   localparam int STRENGTH_W = 20;

   // fades
   localparam int CAM_W = 24;
   localparam int OBJ_W = 17;
   localparam logic [CAM_W-1:0] CAM_FADE = 24'd9437184;
   localparam logic [OBJ_W-1:0] OBJ_FADE = 17'd82944;
   localparam int X1_W = 20;
   localparam int Y2_W = 23;
   localparam int CAM_RECIP_W = 16;
   localparam int OBJ_RECIP_W = 24;
   localparam logic [CAM_RECIP_W-1:0] CAM_RECIP = 16'd58254;
   localparam logic [OBJ_RECIP_W-1:0] OBJ_RECIP = 24'd13256071;
   localparam int CAM_SHIFT = 19;
   localparam int OBJ_SHIFT = 30;
   localparam int FADE_W = 17;
   localparam int KK_W   = 33;

   // darkening and output
   localparam int A_W     = STRENGTH_W + KK_W;
   localparam int T_W     = A_W + 2;
   localparam int T_SHIFT = 49;
   localparam int X_W     = T_SHIFT + 1;
   localparam int SH_W    = X_W + 8;
   localparam int SHADE_W = 8;
   localparam logic [X_W-1:0]  T_ONE = {1'b1, {T_SHIFT{1'b0}}};
   localparam logic [SH_W-1:0] T_HALF = {{(SH_W-T_SHIFT){1'b0}}, 1'b1, {(T_SHIFT-1){1'b0}}};

   typedef struct packed {
      logic            pass;
      logic [KK_W-1:0] kk;
   } side_type;

endpackage

[design/svs_isqrt.sv]
module svs_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [svs_pkg::SQ_W-1:0]   in_rad,
   input  svs_pkg::side_type          in_side,
   output logic                       out_valid,
   output logic [svs_pkg::ROOT_W-1:0] out_root,
   output svs_pkg::side_type          out_side
);
   import svs_pkg::*;

   logic              v_ff    [ROOT_W];
   logic [SQ_W-1:0]   rad_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   side_type          side_ff [ROOT_W];

   // one root bit per stage, two radicand bits consumed per stage
   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic              cv;
      logic [SQ_W-1:0]   crad;
      logic [REM_W-1:0]  crem;
      logic [ROOT_W-1:0] croot;
      side_type          cside;
      logic [REM_W-1:0]  trem;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (i == 0) begin : g_first
         assign cv    = in_valid;
         assign crad  = in_rad;
         assign crem  = '0;
         assign croot = '0;
         assign cside = in_side;
      end else begin : g_next
         assign cv    = v_ff[i-1];
         assign crad  = rad_ff[i-1];
         assign crem  = rem_ff[i-1];
         assign croot = root_ff[i-1];
         assign cside = side_ff[i-1];
      end

      always_comb begin
         trem  = {crem[REM_W-3:0], crad[SQ_W-1 -: 2]};
         trial = {croot, 2'b01};
         if (trem >= trial) begin
            rem_in  = trem - trial;
            root_in = {croot[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = trem;
            root_in = {croot[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= cv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[i]  <= {crad[SQ_W-3:0], 2'b00};
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            side_ff[i] <= cside;
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

[design/svs_div.sv]
module svs_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [svs_pkg::NUM_W-1:0]  in_num,
   input  logic [svs_pkg::DEN_W-1:0]  in_den,
   input  svs_pkg::side_type          in_side,
   output logic                       out_valid,
   output logic [svs_pkg::QUOT_W-1:0] out_quot,
   output svs_pkg::side_type          out_side
);
   import svs_pkg::*;

   logic              v_ff    [QUOT_W];
   logic [DEN_W-1:0]  rem_ff  [QUOT_W];
   logic [DEN_W-1:0]  den_ff  [QUOT_W];
   logic [QUOT_W-1:0] lo_ff   [QUOT_W];
   logic [QUOT_W-1:0] quot_ff [QUOT_W];
   side_type          side_ff [QUOT_W];

   // restoring division, one quotient bit per stage; the high dividend bits
   // are below the divisor, so they seed the remainder
   for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
      logic              cv;
      logic [DEN_W-1:0]  crem;
      logic [DEN_W-1:0]  cden;
      logic [QUOT_W-1:0] clo;
      logic [QUOT_W-1:0] cquot;
      side_type          cside;
      logic [DEN_W:0]    trem;
      logic [DEN_W-1:0]  rem_in;
      logic [QUOT_W-1:0] quot_in;

      if (i == 0) begin : g_first
         assign cv    = in_valid;
         assign crem  = DEN_W'(in_num[NUM_W-1:QUOT_W]);
         assign cden  = in_den;
         assign clo   = in_num[QUOT_W-1:0];
         assign cquot = '0;
         assign cside = in_side;
      end else begin : g_next
         assign cv    = v_ff[i-1];
         assign crem  = rem_ff[i-1];
         assign cden  = den_ff[i-1];
         assign clo   = lo_ff[i-1];
         assign cquot = quot_ff[i-1];
         assign cside = side_ff[i-1];
      end

      always_comb begin
         trem = {crem, clo[QUOT_W-1]};
         if (trem >= {1'b0, cden}) begin
            rem_in  = DEN_W'(trem - {1'b0, cden});
            quot_in = {cquot[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in  = trem[DEN_W-1:0];
            quot_in = {cquot[QUOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= cv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            den_ff[i]  <= cden;
            lo_ff[i]   <= {clo[QUOT_W-2:0], 1'b0};
            quot_ff[i] <= quot_in;
            side_ff[i] <= cside;
         end
      end
   end

   assign out_valid = v_ff[QUOT_W-1];
   assign out_quot  = quot_ff[QUOT_W-1];
   assign out_side  = side_ff[QUOT_W-1];

endmodule

[design/shadow_vertex_shade.sv]
// channel   direction  handshake            word
// req       in         req_valid/req_stall  req_pos_x/y/z, req_normal_x/y/z
// rsp       out        rsp_valid/rsp_stall  rsp_shade
// csr       in         csr_write            csr_index, csr_data
//
// one word per cycle sustained while no result is stalled; 7 front stages + 21 root stages
// + 20 divide stages + 3 back stages, the depth set mostly by the bit-per-stage
// square root and strength divider
// reset is synchronous, active high, clears valid bits and config registers
// a stalled result freezes the whole pipe; req_stall follows it
module shadow_vertex_shade #(
   parameter int COORD_WIDTH = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic signed [svs_pkg::NORMAL_W-1:0] req_normal_x,
   input  logic signed [svs_pkg::NORMAL_W-1:0] req_normal_y,
   input  logic signed [svs_pkg::NORMAL_W-1:0] req_normal_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [svs_pkg::SHADE_W-1:0]  rsp_shade,
   input  logic                         csr_write,
   input  logic [svs_pkg::IDX_W-1:0]    csr_index,
   input  logic [svs_pkg::CSR_W-1:0]    csr_data
);
   import svs_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int DW     = CW + 1;
   localparam int MAG_W  = (DW > SAT_W) ? DW : SAT_W;
   localparam int PACK_W = 3 * CW;
   localparam int PP_W   = DW + NORMAL_W;
   localparam int DOTP_W = PP_W + 2;
   localparam int PD_W   = 2 * DIR_W;
   localparam int DOTD_W = PD_W + 2;

   // pipe advance: everything moves unless a finished word is held
   logic en;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic                        light_is_dir_ff;
   logic [CSR_W-1:0]            light_pos_ff;
   logic [3*DIR_W-1:0]          light_dir_ff;
   logic [RANGE_W-1:0]          light_range_ff;
   logic [ENERGY_W-1:0]         light_energy_ff;
   logic [CSR_W-1:0]            camera_pos_ff;
   logic [CSR_W-1:0]            object_center_ff;
   logic [2*RANGE_W-1:0]        range_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_is_dir_ff  <= 1'b0;
         light_pos_ff     <= '0;
         light_dir_ff     <= '0;
         light_range_ff   <= '0;
         light_energy_ff  <= '0;
         camera_pos_ff    <= '0;
         object_center_ff <= '0;
         range_sq_ff      <= '0;
      end else begin
         // range squared is a config constant, registered off the datapath
         range_sq_ff <= light_range_ff * light_range_ff;
         if (csr_write) begin
            case (csr_index)
               REG_LIGHT_IS_DIR:  light_is_dir_ff  <= csr_data[0];
               REG_LIGHT_POS:     light_pos_ff     <= csr_data;
               REG_LIGHT_DIR:     light_dir_ff     <= csr_data[3*DIR_W-1:0];
               REG_LIGHT_RANGE:   light_range_ff   <= csr_data[RANGE_W-1:0];
               REG_LIGHT_ENERGY:  light_energy_ff  <= csr_data[ENERGY_W-1:0];
               REG_CAMERA_POS:    camera_pos_ff    <= csr_data;
               REG_OBJECT_CENTER: object_center_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // packed coordinate fields; a field above the register reads as zero
   function automatic logic signed [CW-1:0] field(input logic [CSR_W-1:0] word_v,
                                                  input int k);
      logic [PACK_W+CSR_W-1:0] ext;
      ext = {{PACK_W{1'b0}}, word_v};
      return ext[k*CW +: CW];
   endfunction

   // magnitude of a difference, saturated at 2^20
   function automatic logic [SAT_W-1:0] sat_abs(input logic signed [DW-1:0] d);
      logic [DW-1:0]    mag;
      logic [MAG_W-1:0] wide;
      mag  = d[DW-1] ? (~d + DW'(1)) : d;
      wide = MAG_W'(mag);
      if (wide > MAG_W'(DIFF_LIMIT)) begin
         return DIFF_LIMIT;
      end
      return wide[SAT_W-1:0];
   endfunction

   logic signed [CW-1:0]       pos  [3];
   logic signed [NORMAL_W-1:0] nrm  [3];
   logic signed [CW-1:0]       lp   [3];
   logic signed [CW-1:0]       cp   [3];
   logic signed [CW-1:0]       oc   [3];
   logic signed [DIR_W-1:0]    dirc [3];

   assign pos[0] = req_pos_x;
   assign pos[1] = req_pos_y;
   assign pos[2] = req_pos_z;
   assign nrm[0] = req_normal_x;
   assign nrm[1] = req_normal_y;
   assign nrm[2] = req_normal_z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lp[k]   = field(light_pos_ff, k);
         cp[k]   = field(camera_pos_ff, k);
         oc[k]   = field(object_center_ff, k);
         dirc[k] = light_dir_ff[k*DIR_W +: DIR_W];
      end
   end

   // ---------------------------------------------------------------
   // stage 1: coordinate differences
   // ---------------------------------------------------------------
   logic                       v1_ff;
   logic signed [DW-1:0]       dl_ff   [3];
   logic signed [DW-1:0]       dc_ff   [3];
   logic signed [DW-1:0]       dobj_ff [3];
   logic signed [NORMAL_W-1:0] n1_ff   [3];
   logic signed [DW-1:0]       dl_in   [3];
   logic signed [DW-1:0]       dc_in   [3];
   logic signed [DW-1:0]       dobj_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dl_in[k]   = {lp[k][CW-1], lp[k]} - {pos[k][CW-1], pos[k]};
         dc_in[k]   = {pos[k][CW-1], pos[k]} - {cp[k][CW-1], cp[k]};
         dobj_in[k] = {pos[k][CW-1], pos[k]} - {oc[k][CW-1], oc[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dl_ff   <= dl_in;
         dc_ff   <= dc_in;
         dobj_ff <= dobj_in;
         n1_ff   <= nrm;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: squares and dot-product terms
   // ---------------------------------------------------------------
   logic                     v2_ff;
   logic [SQ_W-1:0]          sql_ff [3];
   logic [SQ_W-1:0]          sqc_ff [3];
   logic [SQ_W-1:0]          sqo_ff [3];
   logic signed [PP_W-1:0]   pp_ff  [3];
   logic signed [PD_W-1:0]   pd_ff  [3];
   logic [SQ_W-1:0]          sql_in [3];
   logic [SQ_W-1:0]          sqc_in [3];
   logic [SQ_W-1:0]          sqo_in [3];
   logic signed [PP_W-1:0]   pp_in  [3];
   logic signed [PD_W-1:0]   pd_in  [3];
   logic [SAT_W-1:0]         al, ac, ao;

   always_comb begin
      al = '0;
      ac = '0;
      ao = '0;
      for (int k = 0; k < 3; k++) begin
         al        = sat_abs(dl_ff[k]);
         ac        = sat_abs(dc_ff[k]);
         ao        = sat_abs(dobj_ff[k]);
         sql_in[k] = SQ_W'(al) * SQ_W'(al);
         sqc_in[k] = SQ_W'(ac) * SQ_W'(ac);
         sqo_in[k] = SQ_W'(ao) * SQ_W'(ao);
         pp_in[k]  = dl_ff[k] * n1_ff[k];
         pd_in[k]  = dirc[k] * n1_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sql_ff <= sql_in;
         sqc_ff <= sqc_in;
         sqo_ff <= sqo_in;
         pp_ff  <= pp_in;
         pd_ff  <= pd_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: sums
   // ---------------------------------------------------------------
   logic                     v3_ff;
   logic [SQ_W-1:0]          q3_ff, d1_ff, d2_ff;
   logic signed [DOTP_W-1:0] dotp_ff;
   logic signed [DOTD_W-1:0] dotd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q3_ff   <= sql_ff[0] + sql_ff[1] + sql_ff[2];
         d1_ff   <= sqc_ff[0] + sqc_ff[1] + sqc_ff[2];
         d2_ff   <= sqo_ff[0] + sqo_ff[1] + sqo_ff[2];
         dotp_ff <= DOTP_W'(pp_ff[0]) + DOTP_W'(pp_ff[1]) + DOTP_W'(pp_ff[2]);
         dotd_ff <= DOTD_W'(pd_ff[0]) + DOTD_W'(pd_ff[1]) + DOTD_W'(pd_ff[2]);
      end
   end

   // ---------------------------------------------------------------
   // stage 4: lit test, fade clamps
   // ---------------------------------------------------------------
   logic             v4_ff, pass4_ff;
   logic [SQ_W-1:0]  q4_ff;
   logic [X1_W-1:0]  x1_4_ff;
   logic [Y2_W-1:0]  y2_4_ff;
   logic             pass_in;
   logic [CAM_W-1:0] d1c, cam_left;
   logic [OBJ_W-1:0] d2c, obj_left;

   always_comb begin
      if (light_is_dir_ff) begin
         pass_in = dotd_ff[DOTD_W-1];
      end else begin
         pass_in = (q3_ff <= SQ_W'(range_sq_ff)) && !dotp_ff[DOTP_W-1] && (|dotp_ff);
      end
      d1c      = (d1_ff > SQ_W'(CAM_FADE)) ? CAM_FADE : d1_ff[CAM_W-1:0];
      d2c      = (d2_ff > SQ_W'(OBJ_FADE)) ? OBJ_FADE : d2_ff[OBJ_W-1:0];
      cam_left = CAM_FADE - d1c;
      obj_left = OBJ_FADE - d2c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pass4_ff <= pass_in;
         q4_ff    <= q3_ff;
         // camera fade divides by 144 = 16 * 9
         x1_4_ff  <= cam_left[CAM_W-1:4];
         y2_4_ff  <= {obj_left, 6'b000000};
      end
   end

   // ---------------------------------------------------------------
   // stage 5: reciprocal products (divide by 9 and by 81)
   // ---------------------------------------------------------------
   logic                         v5_ff, pass5_ff;
   logic [SQ_W-1:0]              q5_ff;
   logic [X1_W-1:0]              x1_5_ff;
   logic [Y2_W-1:0]              y2_5_ff;
   logic [X1_W+CAM_RECIP_W-1:0]  p1_ff;
   logic [Y2_W+OBJ_RECIP_W-1:0]  p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pass5_ff <= pass4_ff;
         q5_ff    <= q4_ff;
         x1_5_ff  <= x1_4_ff;
         y2_5_ff  <= y2_4_ff;
         p1_ff    <= (X1_W+CAM_RECIP_W)'(x1_4_ff) * (X1_W+CAM_RECIP_W)'(CAM_RECIP);
         p2_ff    <= (Y2_W+OBJ_RECIP_W)'(y2_4_ff) * (Y2_W+OBJ_RECIP_W)'(OBJ_RECIP);
      end
   end

   // ---------------------------------------------------------------
   // stage 6: quotient correction, the estimate is at most one low
   // ---------------------------------------------------------------
   logic              v6_ff, pass6_ff;
   logic [SQ_W-1:0]   q6_ff;
   logic [FADE_W-1:0] k1_ff, k2_ff;
   logic [FADE_W-1:0] e1, e2, k1_in, k2_in;
   logic [X1_W-1:0]   r1;
   logic [Y2_W-1:0]   r2;

   always_comb begin
      e1 = p1_ff[CAM_SHIFT +: FADE_W];
      e2 = p2_ff[OBJ_SHIFT +: FADE_W];
      r1 = x1_5_ff - ({e1, 3'b000} + X1_W'(e1));
      r2 = y2_5_ff - ({e2, 6'b000000} + Y2_W'({e2, 4'b0000}) + Y2_W'(e2));
      k1_in = (r1 >= X1_W'(9))  ? e1 + FADE_W'(1) : e1;
      k2_in = (r2 >= Y2_W'(81)) ? e2 + FADE_W'(1) : e2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pass6_ff <= pass5_ff;
         q6_ff    <= q5_ff;
         k1_ff    <= k1_in;
         k2_ff    <= k2_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 7: combined fade factor
   // ---------------------------------------------------------------
   logic                v7_ff;
   logic [SQ_W-1:0]     q7_ff;
   side_type            side7_ff;
   logic [2*FADE_W-1:0] kk_wide;

   assign kk_wide = (2*FADE_W)'(k1_ff) * (2*FADE_W)'(k2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q7_ff         <= q6_ff;
         side7_ff.pass <= pass6_ff;
         side7_ff.kk   <= kk_wide[KK_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // distance root, then strength = energy*1024 / (64 + root)
   // ---------------------------------------------------------------
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   side_type          sq_side;
   logic              dv_valid;
   logic [QUOT_W-1:0] dv_quot;
   side_type          dv_side;

   svs_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v7_ff),
      .in_rad    (q7_ff),
      .in_side   (side7_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   svs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_num    ({light_energy_ff, 10'b0000000000}),
      .in_den    (DEN_W'(sq_root) + DEN_W'(64)),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   // ---------------------------------------------------------------
   // back stage a: strength times fade factor
   // ---------------------------------------------------------------
   logic                  va_ff;
   logic [A_W-1:0]        a_ff;
   logic [STRENGTH_W-1:0] s_in;

   always_comb begin
      if (!dv_side.pass) begin
         s_in = '0;
      end else if (light_is_dir_ff) begin
         s_in = {light_energy_ff, 4'b0000};
      end else begin
         s_in = dv_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= A_W'(s_in) * A_W'(dv_side.kk);
      end
   end

   // ---------------------------------------------------------------
   // back stage b: darkening t = 3a, saturation, 1 - t
   // ---------------------------------------------------------------
   logic           vt_ff, sat_ff;
   logic [X_W-1:0] x_ff;
   logic [T_W-1:0] t_in;

   assign t_in = {1'b0, a_ff, 1'b0} + T_W'(a_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff <= 1'b0;
      end else if (en) begin
         vt_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff <= |t_in[T_W-1:T_SHIFT];
         x_ff   <= T_ONE - {1'b0, t_in[T_SHIFT-1:0]};
      end
   end

   // ---------------------------------------------------------------
   // output word: 255 * (1 - t), rounded half up
   // ---------------------------------------------------------------
   logic                rsp_valid_ff;
   logic [SHADE_W-1:0]  rsp_shade_ff;
   logic [SH_W-1:0]     sh_in;

   assign sh_in = {x_ff, 8'b00000000} - SH_W'(x_ff) + T_HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_shade_ff <= sat_ff ? '0 : sh_in[T_SHIFT +: SHADE_W];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_shade = rsp_shade_ff;

`ifndef SYNTHESIS
   // fade factors never exceed one in Q16
   a_fade_range: assert property (@(posedge clock) disable iff (reset)
      v6_ff |-> (k1_ff <= FADE_W'(65536)) && (k2_ff <= FADE_W'(65536)))
      else $error("fade factor above one");

   // combined fade factor stays within Q32 one
   a_kk_range: assert property (@(posedge clock) disable iff (reset)
      v7_ff |-> side7_ff.kk <= {1'b1, 32'h0})
      else $error("combined fade above one");

   // zero darkening gives full shade with no saturation
   a_zero_dark: assert property (@(posedge clock) disable iff (reset)
      (en && va_ff && a_ff == '0) |=> (x_ff == T_ONE) && !sat_ff)
      else $error("zero darkening mishandled");

   // nothing leaves the pipe right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid after reset");
`endif

endmodule
